@@ design/horizontal_line_resampler_macros.svh @@
// assertion macros for the horizontal line resampler
`ifndef HORIZONTAL_LINE_RESAMPLER_MACROS_SVH
`define HORIZONTAL_LINE_RESAMPLER_MACROS_SVH

// same-cycle implication, quiet during reset
`define HLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlr assertion failed");

// next-cycle implication, quiet during reset
`define HLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlr assertion failed");

`endif

@@ design/hlr_pkg.sv @@
// shared constants, types and kernel tables of the horizontal line resampler
`timescale 1ns / 1ps
package hlr_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_TAPS     = 64;
  localparam int KERNEL_STEPS = 64;
  localparam int KTAB_LEN     = 3 * KERNEL_STEPS + 1;
  localparam int KIDX_W       = $clog2(KTAB_LEN);
  localparam int DIV_W        = 40;
  localparam int Q_W          = 36;

  // action codes
  localparam logic ACT_STORE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SOURCE_WIDTH = 2'd0;
  localparam logic [1:0] REG_TARGET_WIDTH = 2'd1;
  localparam logic [1:0] REG_KERNEL_KIND  = 2'd2;

  typedef logic signed [15:0] ktab_t [KTAB_LEN];

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  // unsigned quotient by shift and subtract, used only while building tables
  function automatic longint udiv(longint num, longint den);
    longint unsigned n_u;
    longint unsigned d_u;
    longint unsigned q;
    longint unsigned rem;
    n_u = num;
    d_u = den;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n_u[b]};
      if (rem >= d_u) begin
        rem  = rem - d_u;
        q[b] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  // sin(pi n / m) in q30, taylor series on the reduced angle
  function automatic longint sin_pi_ratio(longint n, longint m);
    longint r;
    longint a;
    longint a2;
    longint term;
    longint sum;
    bit     neg;
    r   = n - udiv(n, 2 * m) * (2 * m);
    neg = 1'b0;
    if (r >= m) begin
      neg = 1'b1;
      r   = r - m;
    end
    if (2 * r > m) r = m - r;
    a    = udiv(PI_Q30 * r, m);
    a2   = (a * a) >>> 30;
    sum  = a;
    term = a;
    for (int k = 1; k <= 7; k++) begin
      term = udiv((term * a2) >>> 30, longint'((2 * k) * (2 * k + 1)));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return neg ? -sum : sum;
  endfunction

  // rounding divide, halves away from zero
  function automatic longint div_round(longint num, longint den);
    if (num < 0) return -udiv(-num + (den >>> 1), den);
    return udiv(num + (den >>> 1), den);
  endfunction

  // lanczos-3 table in q2.14
  function automatic ktab_t build_lanczos();
    ktab_t            tab;
    longint unsigned  pisq;
    longint           pi2_q16;
    longint           s1;
    longint           s2;
    longint           m1;
    longint           m2;
    longint           prod;
    longint           kk;
    pisq    = 64'd3373259426 * 64'd3373259426;
    pi2_q16 = longint'(pisq >> 44);
    kk      = KERNEL_STEPS;
    for (int i = 0; i < KTAB_LEN; i++) begin
      if (i == 0) begin
        tab[i] = 16'sd16384;
      end else begin
        s1   = sin_pi_ratio(longint'(i), kk);
        s2   = sin_pi_ratio(longint'(i), 3 * kk);
        m1   = (s1 < 0) ? -s1 : s1;
        m2   = (s2 < 0) ? -s2 : s2;
        prod = (m1 * m2) >>> 30;
        if ((s1 < 0) != (s2 < 0)) prod = -prod;
        tab[i] = 16'(div_round(prod * 3 * kk * kk, pi2_q16 * i * i));
      end
    end
    return tab;
  endfunction

  // mitchell b = c = 1/3 table in q2.14
  function automatic ktab_t build_mitchell();
    ktab_t  tab;
    longint kk;
    longint k3;
    longint n;
    longint ii;
    kk = KERNEL_STEPS;
    k3 = kk * kk * kk;
    for (int i = 0; i < KTAB_LEN; i++) begin
      ii = i;
      if (ii < kk) n = 16 * k3 - 36 * ii * ii * kk + 21 * ii * ii * ii;
      else if (ii < 2 * kk)
        n = 32 * k3 - 60 * ii * kk * kk + 36 * ii * ii * kk - 7 * ii * ii * ii;
      else n = 0;
      tab[i] = 16'(div_round(n * 16384, 18 * k3));
    end
    return tab;
  endfunction

  localparam ktab_t LANCZOS_TAB  = build_lanczos();
  localparam ktab_t MITCHELL_TAB = build_mitchell();

endpackage

@@ design/hlr_div.sv @@
// shared radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module hlr_div import hlr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] den_q;
  logic [DIV_W+1:0] shifted;
  logic [DIV_W+1:0] trial;

  // trial subtract of the shifted partial remainder
  assign shifted = {1'b0, rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go && !busy_q) begin
        quo_q  <= req_i.num;
        rem_q  <= '0;
        den_q  <= req_i.den;
        cnt_q  <= CNT_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!trial[DIV_W+1]) begin
          rem_q <= trial[DIV_W-1:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[DIV_W-1:0];
          quo_q <= {quo_q[DIV_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ design/horizontal_line_resampler.sv @@
// top level of the horizontal line resampler: registers, line store, sequencer
//
// channel   | handshake                     | payload
// ----------+-------------------------------+--------------------------------------
// input     | start, busy                   | action_i, position_i, sample_value_i
// result    | result_valid_o (strobe)       | pixel_value_o, pixel_index_o,
//           |                               | window_clipped_o
// config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// a store item is written to the line store and busy stays low.
// a compute item holds busy through 40-bit divides on the shared divider (window
// start, window end, kernel step, kernel index, normalization), setup and output,
// and per tap a line store read, then a multiply-accumulate; a window that starts
// at sample 0 saves one divide and an empty window ends after the end divide.
// a window crossing the output pixel center adds one kernel index divide.
// reset clears the registers to widths of 1 and the lanczos kernel; the line
// store is not cleared. the result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
module horizontal_line_resampler import hlr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic [11:0]        position_i,
  input  logic signed [15:0] sample_value_i,
  output logic               result_valid_o,
  output logic [7:0]         pixel_value_o,
  output logic [11:0]        pixel_index_o,
  output logic               window_clipped_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

`include "horizontal_line_resampler_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_XW, S_LO, S_ST_DIV, S_EN_DIV, S_WIN, S_STEP_DIV, S_OFF,
    S_IDX_GO, S_IDX_DIV, S_RD, S_MAC, S_NORM, S_NORM_DIV, S_OUT
  } state_e;

  state_e state_q;

  logic [12:0] src_q;
  logic [12:0] dst_q;
  logic        kind_q;

  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd_data_q;

  logic [11:0]        pos_q;
  logic [24:0]        xw_q;
  logic [25:0]        start_q;
  logic [11:0]        end_q;
  logic [11:0]        sx_q;
  logic               clip_q;
  logic [7:0]         pix_q;
  logic [KIDX_W-1:0]  step_q;
  logic [13:0]        step_r_q;
  logic signed [26:0] o_q;
  logic signed [Q_W-1:0] q_q;
  logic signed [15:0] r_q;
  logic signed [15:0] wt_q;
  logic signed [37:0] acc_q;
  logic signed [21:0] wsum_q;

  logic             div_go_q;
  logic [DIV_W-1:0] div_num_q;
  logic [DIV_W-1:0] div_den_q;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic        cfg_wr;
  logic        accept;
  logic [12:0] w_eff;
  logic [12:0] nw_eff;
  logic [12:0] d_w;
  logic [13:0] dd2;
  logic [14:0] rad_d;
  logic [KIDX_W-1:0] rad_lim;
  logic signed [26:0] lo_s;
  logic [25:0] hi_u;
  logic [12:0] n_w;
  logic [11:0] sx_clip;
  logic [24:0] sx_nw;
  logic [26:0] o_abs;
  logic signed [26:0] o_nx;
  logic signed [Q_W-1:0] q_nx;
  logic signed [15:0] r_nx;
  logic signed [15:0] r_tmp;
  logic signed [15:0] wt_sel;
  logic signed [31:0] mac_prod;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= 13'd1;
      dst_q  <= 13'd1;
      kind_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SOURCE_WIDTH: src_q  <= pwdata[12:0];
        REG_TARGET_WIDTH: dst_q  <= pwdata[12:0];
        REG_KERNEL_KIND:  kind_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SOURCE_WIDTH: prdata = {19'b0, src_q};
      REG_TARGET_WIDTH: prdata = {19'b0, dst_q};
      REG_KERNEL_KIND:  prdata = {31'b0, kind_q};
      default:          prdata = '0;
    endcase
  end

  // effective widths and window geometry
  assign w_eff  = (src_q == 13'd0) ? 13'd1 :
                  (src_q > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : src_q;
  assign nw_eff = (dst_q == 13'd0) ? 13'd1 :
                  (dst_q > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : dst_q;
  assign d_w     = (w_eff > nw_eff) ? w_eff : nw_eff;
  assign dd2     = {d_w, 1'b0};
  assign rad_d   = kind_q ? {1'b0, d_w, 1'b0} : ({2'b00, d_w} + {1'b0, d_w, 1'b0});
  assign rad_lim = kind_q ? KIDX_W'(2 * KERNEL_STEPS) : KIDX_W'(3 * KERNEL_STEPS);
  assign lo_s    = $signed({2'b00, xw_q}) - $signed({12'b0, rad_d});
  assign hi_u    = {1'b0, xw_q} + {11'b0, rad_d};
  assign n_w     = {1'b0, end_q} - {1'b0, start_q[11:0]} + 13'd1;
  assign sx_clip = start_q[11:0] + 12'((n_w - 13'(MAX_TAPS)) >> 1);
  assign sx_nw   = 25'(sx_q) * 25'(nw_eff);
  assign o_abs   = o_q[26] ? 27'(-o_q) : 27'(o_q);
  assign o_nx    = o_q + $signed({14'b0, nw_eff});

  // incremental update of the kernel index quotient and remainder
  always_comb begin
    r_tmp = '0;
    if (o_q[26]) begin
      r_tmp = r_q - $signed({2'b00, step_r_q});
      q_nx  = q_q - $signed(Q_W'(step_q));
      r_nx  = r_tmp;
      if (r_tmp < 0) begin
        r_nx = r_tmp + $signed({2'b00, dd2});
        q_nx = q_q - $signed(Q_W'(step_q)) - Q_W'(1);
      end
    end else begin
      r_tmp = r_q + $signed({2'b00, step_r_q});
      q_nx  = q_q + $signed(Q_W'(step_q));
      r_nx  = r_tmp;
      if (r_tmp >= $signed({2'b00, dd2})) begin
        r_nx = r_tmp - $signed({2'b00, dd2});
        q_nx = q_q + $signed(Q_W'(step_q)) + Q_W'(1);
      end
    end
  end

  // kernel weight lookup
  always_comb begin
    wt_sel = '0;
    if (q_q <= $signed(Q_W'(rad_lim))) begin
      wt_sel = kind_q ? MITCHELL_TAB[q_q[KIDX_W-1:0]] : LANCZOS_TAB[q_q[KIDX_W-1:0]];
    end
  end

  assign mac_prod = $signed(rd_data_q) * wt_q;

  // line store
  always_ff @(posedge clk_i) begin
    if (accept && action_i == ACT_STORE) line_mem[position_i] <= sample_value_i;
    if (state_q == S_RD) rd_data_q <= line_mem[sx_q];
  end

  assign accept = start && !busy;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && action_i == ACT_COMPUTE) begin
            pos_q   <= position_i;
            acc_q   <= '0;
            wsum_q  <= '0;
            clip_q  <= 1'b0;
            pix_q   <= '0;
            state_q <= S_XW;
          end
        end
        S_XW: begin
          xw_q    <= 25'(pos_q) * 25'(w_eff);
          state_q <= S_LO;
        end
        S_LO: begin
          div_go_q <= 1'b1;
          if (lo_s <= 0) begin
            start_q   <= '0;
            div_num_q <= DIV_W'(hi_u);
            div_den_q <= DIV_W'(nw_eff);
            state_q   <= S_EN_DIV;
          end else begin
            div_num_q <= DIV_W'(lo_s[25:0]) + DIV_W'(nw_eff) - DIV_W'(1);
            div_den_q <= DIV_W'(nw_eff);
            state_q   <= S_ST_DIV;
          end
        end
        S_ST_DIV: begin
          if (div_rsp.done) begin
            start_q   <= div_rsp.quo[25:0];
            div_go_q  <= 1'b1;
            div_num_q <= DIV_W'(hi_u);
            div_den_q <= DIV_W'(nw_eff);
            state_q   <= S_EN_DIV;
          end
        end
        S_EN_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > DIV_W'(w_eff - 13'd1)) end_q <= 12'(w_eff - 13'd1);
            else end_q <= div_rsp.quo[11:0];
            state_q <= S_WIN;
          end
        end
        S_WIN: begin
          if (start_q > {14'b0, end_q}) begin
            state_q <= S_OUT;
          end else begin
            if (n_w > 13'(MAX_TAPS)) begin
              sx_q   <= sx_clip;
              end_q  <= sx_clip + 12'(MAX_TAPS - 1);
              clip_q <= 1'b1;
            end else begin
              sx_q <= start_q[11:0];
            end
            div_go_q  <= 1'b1;
            div_num_q <= DIV_W'(nw_eff) * DIV_W'(2 * KERNEL_STEPS);
            div_den_q <= DIV_W'(dd2);
            state_q   <= S_STEP_DIV;
          end
        end
        S_STEP_DIV: begin
          if (div_rsp.done) begin
            step_q   <= div_rsp.quo[KIDX_W-1:0];
            step_r_q <= div_rsp.rem[13:0];
            state_q  <= S_OFF;
          end
        end
        S_OFF: begin
          o_q     <= $signed({2'b00, sx_nw}) - $signed({2'b00, xw_q});
          state_q <= S_IDX_GO;
        end
        S_IDX_GO: begin
          div_go_q  <= 1'b1;
          div_num_q <= DIV_W'(o_abs) * DIV_W'(2 * KERNEL_STEPS) + DIV_W'(d_w);
          div_den_q <= DIV_W'(dd2);
          state_q   <= S_IDX_DIV;
        end
        S_IDX_DIV: begin
          if (div_rsp.done) begin
            q_q     <= $signed({1'b0, div_rsp.quo[Q_W-2:0]});
            r_q     <= $signed({2'b00, div_rsp.rem[13:0]});
            state_q <= S_RD;
          end
        end
        S_RD: begin
          wt_q    <= wt_sel;
          state_q <= S_MAC;
        end
        S_MAC: begin
          acc_q  <= acc_q + 38'(mac_prod);
          wsum_q <= wsum_q + 22'(wt_q);
          if (sx_q == end_q) begin
            state_q <= S_NORM;
          end else begin
            sx_q <= sx_q + 12'd1;
            o_q  <= o_nx;
            if (o_q[26] && !o_nx[26]) begin
              state_q <= S_IDX_GO;
            end else begin
              q_q     <= q_nx;
              r_q     <= r_nx;
              state_q <= S_RD;
            end
          end
        end
        S_NORM: begin
          if (wsum_q > 0 && acc_q > 0) begin
            div_go_q  <= 1'b1;
            div_num_q <= {1'b0, acc_q, 1'b0} + {14'b0, wsum_q, 4'b0};
            div_den_q <= {13'b0, wsum_q, 5'b0};
            state_q   <= S_NORM_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_NORM_DIV: begin
          if (div_rsp.done) begin
            pix_q   <= (|div_rsp.quo[DIV_W-1:8]) ? 8'd255 : div_rsp.quo[7:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // shared divider
  assign div_req.go  = div_go_q;
  assign div_req.num = div_num_q;
  assign div_req.den = div_den_q;

  hlr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result ports
  assign busy             = (state_q != S_IDLE);
  assign result_valid_o   = (state_q == S_OUT);
  assign pixel_value_o    = pix_q;
  assign pixel_index_o    = pos_q;
  assign window_clipped_o = clip_q;

  // checks
  `HLR_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `HLR_ASSERT_NEXT(a_compute_busy, clk_i, rst_ni, accept && action_i == ACT_COMPUTE, busy)
  `HLR_ASSERT_NEXT(a_store_idle, clk_i, rst_ni, accept && action_i == ACT_STORE, !busy)
  `HLR_ASSERT_IMP(a_tap_in_window, clk_i, rst_ni, state_q == S_MAC, sx_q <= end_q)

endmodule
